/* design/lspb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB setpoint package
// Shared widths, codes and item types of the LSPB setpoint generator.
// ----------------------------------------------------------------------------
package lspb_pkg;

  localparam int POS_W   = 32;
  localparam int TIME_W  = 16;
  localparam int DUR_W   = TIME_W - 1;
  localparam int SQ_W    = 2 * DUR_W;
  localparam int POLY_W  = SQ_W + 7;
  localparam int MAG_W   = POLY_W - 1;
  localparam int HALF_W  = MAG_W / 2;
  localparam int PP_W    = POS_W + HALF_W;
  localparam int NUM_W   = POS_W + MAG_W;
  localparam int DEN_W   = SQ_W + 2;
  localparam int DIV_N   = POS_W;

  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_TARGET   = 1'b1;

  localparam logic [1:0] REGION_ACCEL  = 2'd0;
  localparam logic [1:0] REGION_CRUISE = 2'd1;
  localparam logic [1:0] REGION_DECEL  = 2'd2;

  typedef struct packed {
    logic             err;
    logic             at_end;
    logic [1:0]       region;
    logic [DUR_W-1:0] tu;
    logic [SQ_W-1:0]  tt;
    logic [SQ_W-1:0]  ttf;
    logic [SQ_W-1:0]  tftf;
  } front_item_t;

  typedef struct packed {
    logic             err;
    logic             at_end;
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] q;
  } div_stage_t;

endpackage

/* design/lspb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB front end
// Accepts time ticks, classifies the profile segment and forms the squares.
// ----------------------------------------------------------------------------
module lspb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lspb_pkg::TIME_W-1:0]  in_time_tick,
  input  logic [lspb_pkg::DUR_W-1:0]   tf,
  output logic                         item_valid,
  input  logic                         item_ready,
  output lspb_pkg::front_item_t        item
);
  import lspb_pkg::*;

  logic             valid_r, valid_nxt;
  front_item_t      item_r, item_nxt;
  logic             in_fire;
  logic             neg_t;
  logic [DUR_W-1:0] tu;
  logic [DUR_W+1:0] t4;
  logic [DUR_W+1:0] tf3;

  assign in_ready = !valid_r || item_ready;
  assign in_fire  = in_valid && in_ready;
  assign neg_t    = in_time_tick[TIME_W-1];
  assign tu       = neg_t ? '0 : in_time_tick[DUR_W-1:0];
  assign t4       = {tu, 2'b00};
  assign tf3      = {2'b00, tf} + {1'b0, tf, 1'b0};

  always_comb begin
    item_nxt        = item_r;
    item_nxt.err    = neg_t;
    item_nxt.at_end = !neg_t && (tu == tf);
    if (t4 < {2'b00, tf}) begin
      item_nxt.region = REGION_ACCEL;
    end else if (t4 < tf3) begin
      item_nxt.region = REGION_CRUISE;
    end else begin
      item_nxt.region = REGION_DECEL;
    end
    item_nxt.tu   = tu;
    item_nxt.tt   = SQ_W'(tu) * SQ_W'(tu);
    item_nxt.ttf  = SQ_W'(tu) * SQ_W'(tf);
    item_nxt.tftf = SQ_W'(tf) * SQ_W'(tf);
    valid_nxt     = in_fire || (valid_r && !item_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_fire) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* design/lspb_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB item queue
// Two-entry queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module lspb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  lspb_pkg::front_item_t push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output lspb_pkg::front_item_t pop_item
);
  import lspb_pkg::*;

  front_item_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/lspb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB arithmetic back end
// Forms the segment polynomial, scales it by the target and divides it by a
// one-bit-per-stage pipelined divider, then saturates the result.
// ----------------------------------------------------------------------------
module lspb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  lspb_pkg::front_item_t        item,
  input  logic [lspb_pkg::DUR_W-1:0]   tf,
  input  logic [lspb_pkg::POS_W-1:0]   qf,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lspb_pkg::POS_W-1:0]   out_position,
  output logic                         out_time_error,
  output logic                         out_saturated
);
  import lspb_pkg::*;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       r;
    logic [DEN_W:0]   r2;
    r  = s;
    r2 = {s.rem, s.lo[POS_W-1]};
    if (r2 >= {1'b0, s.den}) begin
      r2 = r2 - {1'b0, s.den};
      r.q = {s.q[POS_W-2:0], 1'b1};
    end else begin
      r.q = {s.q[POS_W-2:0], 1'b0};
    end
    r.rem = r2[DEN_W-1:0];
    r.lo  = {s.lo[POS_W-2:0], 1'b0};
    return r;
  endfunction

  logic adv;

  logic              s1_v_r;
  logic              s1_err_r, s1_end_r, s1_neg_r;
  logic [POS_W-1:0]  s1_amag_r;
  logic [MAG_W-1:0]  s1_pmag_r;
  logic [DEN_W-1:0]  s1_den_r;

  logic              s2_v_r;
  logic              s2_err_r, s2_end_r, s2_neg_r;
  logic [PP_W-1:0]   s2_p0_r, s2_p1_r;
  logic [DEN_W-1:0]  s2_den_r;

  logic              s3_v_r;
  logic              s3_err_r, s3_end_r, s3_neg_r;
  logic [NUM_W-1:0]  s3_num_r;
  logic [DEN_W-1:0]  s3_den_r;

  logic              dv_v_r [DIV_N+1];
  div_stage_t        dv_r   [DIV_N+1];

  logic              o_v_r;
  logic [POS_W-1:0]  o_pos_r, o_pos_nxt;
  logic              o_err_r, o_sat_r, o_sat_nxt;

  logic signed [POLY_W-1:0] poly;
  logic [POLY_W-1:0]        pabs;
  logic [DEN_W-1:0]         den;
  logic                     qneg;
  logic [POS_W:0]           qabs;
  div_stage_t               d0;
  div_stage_t               dl;
  logic [POS_W-1:0]         limit;
  logic [POS_W-1:0]         mag;

  assign adv        = !o_v_r || out_ready;
  assign item_ready = adv;

  always_comb begin
    unique case (item.region)
      REGION_ACCEL: begin
        poly = POLY_W'({item.tt, 3'b000});
        den  = DEN_W'({item.tftf, 1'b0}) + DEN_W'(item.tftf);
      end
      REGION_CRUISE: begin
        poly = POLY_W'({item.tu, 3'b000}) - POLY_W'(tf);
        den  = DEN_W'({tf, 2'b00}) + DEN_W'({tf, 1'b0});
      end
      default: begin
        poly = POLY_W'({item.ttf, 4'b0000}) - POLY_W'({item.tt, 3'b000})
             - POLY_W'({item.tftf, 2'b00}) - POLY_W'(item.tftf);
        den  = DEN_W'({item.tftf, 1'b0}) + DEN_W'(item.tftf);
      end
    endcase
    pabs = poly[POLY_W-1] ? (~poly + POLY_W'(1)) : poly;
    qneg = qf[POS_W-1];
    qabs = qneg ? ((~{1'b1, qf}) + (POS_W+1)'(1)) : {1'b0, qf};
  end

  always_comb begin
    d0      = '0;
    d0.err  = s3_err_r;
    d0.at_end = s3_end_r;
    d0.neg  = s3_neg_r;
    d0.ovf  = (s3_num_r[NUM_W-1:POS_W] >= (NUM_W-POS_W)'(s3_den_r));
    d0.den  = s3_den_r;
    d0.rem  = s3_num_r[POS_W+DEN_W-1:POS_W];
    d0.lo   = s3_num_r[POS_W-1:0];
    d0.q    = '0;
  end

  always_comb begin
    dl    = dv_r[DIV_N];
    limit = dl.neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    if (dl.ovf || (dl.q > limit)) begin
      mag       = limit;
      o_sat_nxt = 1'b1;
    end else begin
      mag       = dl.q;
      o_sat_nxt = 1'b0;
    end
    o_pos_nxt = dl.neg ? (~mag + POS_W'(1)) : mag;
    if (dl.err) begin
      o_pos_nxt = '0;
      o_sat_nxt = 1'b0;
    end else if (dl.at_end) begin
      o_pos_nxt = qf;
      o_sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= item_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      o_v_r  <= dv_v_r[DIV_N];
    end
    if (adv) begin
      s1_err_r  <= item.err;
      s1_end_r  <= item.at_end;
      s1_neg_r  <= qneg ^ poly[POLY_W-1];
      s1_amag_r <= qabs[POS_W-1:0];
      s1_pmag_r <= pabs[MAG_W-1:0];
      s1_den_r  <= den;
      s2_err_r  <= s1_err_r;
      s2_end_r  <= s1_end_r;
      s2_neg_r  <= s1_neg_r;
      s2_p0_r   <= PP_W'(s1_amag_r) * PP_W'(s1_pmag_r[HALF_W-1:0]);
      s2_p1_r   <= PP_W'(s1_amag_r) * PP_W'(s1_pmag_r[MAG_W-1:HALF_W]);
      s2_den_r  <= s1_den_r;
      s3_err_r  <= s2_err_r;
      s3_end_r  <= s2_end_r;
      s3_neg_r  <= s2_neg_r;
      s3_num_r  <= NUM_W'(s2_p0_r) + {s2_p1_r, {HALF_W{1'b0}}};
      s3_den_r  <= s2_den_r;
      o_pos_r   <= o_pos_nxt;
      o_err_r   <= dl.err;
      o_sat_r   <= o_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s3_v_r;
    end
    if (adv) begin
      dv_r[0] <= d0;
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (adv) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
    end
  end

  assign out_valid      = o_v_r;
  assign out_position   = o_pos_r;
  assign out_time_error = o_err_r;
  assign out_saturated  = o_sat_r;

endmodule

/* design/lspb_trajectory_point_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB trajectory setpoint generator
// Returns the setpoint at time tick t of a linear-segment, parabolic-blend
// profile from zero to the target position over the programmed duration.
// ----------------------------------------------------------------------------
// The block takes one time tick per cycle while the output is not stalled and
// returns one setpoint per tick, in order, through the front-end register, the
// queue storage, three polynomial and multiply stages, a divider load stage,
// a 32-stage restoring divider that settles one quotient bit per stage, and
// the output register. Configuration must be written only while the block is
// idle.
module lspb_trajectory_point_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lspb_pkg::POS_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lspb_pkg::TIME_W-1:0] in_time_tick,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lspb_pkg::POS_W-1:0]  out_position,
  output logic                        out_time_error,
  output logic                        out_saturated
);
  import lspb_pkg::*;

  logic [DUR_W-1:0] dur_r;
  logic [POS_W-1:0] qf_r;
  logic [DUR_W-1:0] tf;
  logic             f_valid, f_ready;
  front_item_t      f_item;
  logic             q_valid, q_ready;
  front_item_t      q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= DUR_W'(1);
      qf_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DURATION: dur_r <= cfg_wdata[DUR_W-1:0];
        REG_TARGET:   qf_r  <= cfg_wdata;
        default:      qf_r  <= qf_r;
      endcase
    end
  end

  assign tf = (dur_r == '0) ? DUR_W'(1) : dur_r;

  lspb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_time_tick (in_time_tick),
    .tf           (tf),
    .item_valid   (f_valid),
    .item_ready   (f_ready),
    .item         (f_item)
  );

  lspb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  lspb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (q_valid),
    .item_ready     (q_ready),
    .item           (q_item),
    .tf             (tf),
    .qf             (qf_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_time_error (out_time_error),
    .out_saturated  (out_saturated)
  );

endmodule

/* design/lspb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB port checker
// Watches the ports of the setpoint generator for consistent results.
// ----------------------------------------------------------------------------
module lspb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lspb_pkg::POS_W-1:0]  out_position,
  input logic                        out_time_error,
  input logic                        out_saturated
);
  import lspb_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("Stalled result changed before its transfer.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_time_error |-> (out_position == '0) && !out_saturated)
    else $error("Time error result is not a clean zero.");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_position == POS_MAX) || (out_position == POS_MIN))
    else $error("Saturated result is not at a range limit.");

endmodule

bind lspb_trajectory_point_top lspb_checker u_lspb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_position   (out_position),
  .out_time_error (out_time_error),
  .out_saturated  (out_saturated)
);

/* tb/tb_lspb_trajectory_point_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSPB trajectory setpoint generator testbench
// Feeds time ticks under a range of durations and targets, with random gaps
// on both channels, and compares every setpoint, error flag and saturation
// flag with an in-order prediction of the exact rational profile.
// ----------------------------------------------------------------------------
module tb_lspb_trajectory_point_top;
  import lspb_pkg::*;

  typedef struct {
    logic [POS_W-1:0] position;
    logic             time_error;
    logic             saturated;
  } setpoint_t;

  class setpoint_scoreboard;
    logic [DUR_W-1:0] duration;
    logic [POS_W-1:0] target;
    setpoint_t        expected_q[$];

    function new();
      duration = DUR_W'(1);
      target   = '0;
    endfunction

    function void note_tick(logic signed [TIME_W-1:0] tick);
      setpoint_t              sp;
      longint                 t;
      longint                 tf;
      longint                 poly;
      longint                 den;
      logic signed [127:0]    qf;
      logic signed [127:0]    quo;
      t  = tick;
      tf = (duration == 0) ? 1 : duration;
      qf = $signed(target);
      sp.position   = 0;
      sp.time_error = 0;
      sp.saturated  = 0;
      if (t < 0) begin
        sp.time_error = 1;
      end else if (t == tf) begin
        sp.position = target;
      end else begin
        if (4 * t < tf) begin
          poly = 8 * t * t;
          den  = 3 * tf * tf;
        end else if (4 * t < 3 * tf) begin
          poly = 8 * t - tf;
          den  = 6 * tf;
        end else begin
          poly = -5 * tf * tf + 16 * t * tf - 8 * t * t;
          den  = 3 * tf * tf;
        end
        quo = (qf * 128'(signed'(poly))) / 128'(signed'(den));
        if (quo > 128'sd2147483647) begin
          sp.saturated = 1;
          sp.position  = 32'h7fff_ffff;
        end else if (quo < -128'sd2147483648) begin
          sp.saturated = 1;
          sp.position  = 32'h8000_0000;
        end else begin
          sp.position = quo[POS_W-1:0];
        end
      end
      expected_q.push_back(sp);
    endfunction

    function bit check_result(setpoint_t got, output string msg);
      setpoint_t want;
      if (expected_q.size() == 0) begin
        msg = "setpoint transfer with nothing expected";
        return 0;
      end
      want = expected_q.pop_front();
      if (got.position !== want.position || got.time_error !== want.time_error ||
          got.saturated !== want.saturated) begin
        $sformat(msg, "setpoint got %h/%b/%b want %h/%b/%b", got.position,
                 got.time_error, got.saturated, want.position, want.time_error,
                 want.saturated);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic              cfg_index = REG_DURATION;
  logic [POS_W-1:0]  cfg_wdata = 0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [TIME_W-1:0] in_time_tick = 0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [POS_W-1:0]  out_position;
  logic              out_time_error;
  logic              out_saturated;

  setpoint_scoreboard sb = new();
  int                 mismatches = 0;
  int                 ticks_sent = 0;

  lspb_trajectory_point_top u_top (.*);

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int in_idle_pct();
    return (ticks_sent < 650) ? 31 : (ticks_sent < 1300) ? 55 : 0;
  endfunction

  function automatic int out_idle_pct();
    return (ticks_sent < 650) ? 55 : (ticks_sent < 1300) ? 31 : 0;
  endfunction

  always @(posedge clk) begin
    setpoint_t got;
    string     msg;
    if (rst_n && out_valid && out_ready) begin
      got.position   = out_position;
      got.time_error = out_time_error;
      got.saturated  = out_saturated;
      if (!sb.check_result(got, msg)) report_mismatch(msg);
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct());
  end

  task automatic send_tick(int t);
    int gap = 0;
    while ($urandom_range(99) < in_idle_pct()) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1;
    in_time_tick <= t[TIME_W-1:0];
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t[TIME_W-1:0]);
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic program_profile(logic [DUR_W-1:0] tf, logic [POS_W-1:0] qf);
    drain();
    cfg_we    <= 1;
    cfg_index <= REG_DURATION;
    cfg_wdata <= {{(POS_W-DUR_W){1'b0}}, tf};
    @(posedge clk);
    cfg_index <= REG_TARGET;
    cfg_wdata <= qf;
    @(posedge clk);
    cfg_we <= 0;
    sb.duration = tf;
    sb.target   = qf;
  endtask

  initial begin
    int dir_ticks[] = '{-32768, -1, 0, 1, 24, 25, 26, 74, 75, 76, 99, 100, 101, 200,
                        32767};
    int tf;
    int qf;
    int t;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_tick(5);
    program_profile(DUR_W'(100), 32'h7fff_ffff);
    foreach (dir_ticks[i]) send_tick(dir_ticks[i]);
    program_profile(DUR_W'(0), 32'h8000_0000);
    foreach (dir_ticks[i]) if (i < 5) send_tick(dir_ticks[i]);
    program_profile(DUR_W'(32767), 32'h0000_0000);
    send_tick(0);
    send_tick(32767);
    send_tick(-32768);
    send_tick(20000);
    while (ticks_sent < 1950) begin
      case ($urandom_range(3))
        0: tf = 1;
        1: tf = 32767;
        2: tf = $urandom_range(1, 40);
        default: tf = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(4))
        0: qf = 32'h7fff_ffff;
        1: qf = 32'h8000_0000;
        2: qf = 0;
        default: qf = $urandom;
      endcase
      program_profile(tf[DUR_W-1:0], qf);
      repeat (150) begin
        if ($urandom_range(99) < 70) begin
          t = $urandom_range(0, 2 * tf + 4) - 2;
          if (t > 32767) t = 32767;
        end else begin
          t = $signed(16'($urandom));
        end
        send_tick(t);
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("tb_lspb_trajectory_point_top: done, clean");
    end else begin
      $display("tb_lspb_trajectory_point_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_lspb_trajectory_point_top: done, errors");
    $finish;
  end

endmodule
